// ===== design/ctcgsa_pkg.sv =====
// shared types and constants of the ctc greedy sequence accuracy block
`default_nettype none
package ctcgsa_pkg;

  // default sizes of the block
  localparam int MAX_STEPS_DEF   = 256;
  localparam int MAX_CLASSES_DEF = 4096;
  localparam int MAX_LABELS_DEF  = 256;

  // fixed field widths
  localparam int SCORE_BITS = 16;
  localparam int LABEL_BITS = 12;
  localparam int CNT16_BITS = 16;
  localparam int ACC_BITS   = 17;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BLANK_LABEL   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHABET_SIZE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIME_STEPS    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LABEL_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BATCH_SIZE    = 3'd4;

  // item kinds
  localparam logic CMD_SCORE = 1'b0;
  localparam logic CMD_TRUTH = 1'b1;

  // divider: one quotient bit per cycle
  localparam int DIV_STEPS     = 16;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);
  localparam logic [ACC_BITS-1:0] ACC_ONE = 17'h10000;

  typedef struct packed {
    logic                          cmd;
    logic signed [SCORE_BITS-1:0]  score;
    logic [LABEL_BITS-1:0]         truth_label;
  } in_item_t;

  typedef struct packed {
    logic                  sample_hit;
    logic [CNT16_BITS-1:0] hits_so_far;
    logic [CNT16_BITS-1:0] sample_number;
    logic [ACC_BITS-1:0]   accuracy_q16;
    logic                  batch_done;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [CNT16_BITS-1:0] num;
    logic [CNT16_BITS-1:0] den;
  } div_req_t;

endpackage
`default_nettype wire

// ===== design/ctcgsa_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module ctcgsa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/ctcgsa_div.sv =====
// restoring divider for the q1.16 accuracy, one quotient bit per cycle
`default_nettype none
module ctcgsa_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctcgsa_pkg::div_req_t req,
  output logic                     done,
  output logic [ctcgsa_pkg::ACC_BITS-1:0] quo
);

  localparam int NW = ctcgsa_pkg::CNT16_BITS;

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic                                sat_r, sat_nxt;
  logic [ctcgsa_pkg::DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [NW:0]                         rem_r, rem_nxt;
  logic [NW-1:0]                       den_r, den_nxt;
  logic [NW-1:0]                       quo_r, quo_nxt;
  logic [NW:0]                         trial;
  logic                                qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    trial    = {rem_r[NW-1:0], 1'b0};
    qbit     = (trial >= {1'b0, den_r});
    if (req.start) begin
      den_nxt = req.den;
      quo_nxt = '0;
      if (req.num >= req.den) begin
        // ratio of one or more saturates at 1.0
        sat_nxt  = 1'b1;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        sat_nxt  = 1'b0;
        rem_nxt  = {1'b0, req.num};
        cnt_nxt  = ctcgsa_pkg::DIV_CNT_BITS'(ctcgsa_pkg::DIV_STEPS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, den_r}) : trial;
      quo_nxt = {quo_r[NW-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ctcgsa_pkg::DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      sat_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      sat_r  <= sat_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = sat_r ? ctcgsa_pkg::ACC_ONE : {1'b0, quo_r};

endmodule
`default_nettype wire

// ===== design/ctc_greedy_sequence_accuracy_top.sv =====
// ctc greedy decode and sequence accuracy, top level
// flow: score and truth transfers are taken one per cycle when not stalled; the input
//   stalls after the last score of a sample while the decoded store read is primed
// a sample result appears the cycle after its last truth transfer; on the last
//   sample of a batch it waits for the divider, which skips its steps when saturated
// the divider, one quotient bit per cycle, sets the per batch overhead
// reset: synchronous active low; control and counters clear, config registers
//   return to their defaults
`default_nettype none
module ctc_greedy_sequence_accuracy_top #(
  parameter int MAX_STEPS   = ctcgsa_pkg::MAX_STEPS_DEF,
  parameter int MAX_CLASSES = ctcgsa_pkg::MAX_CLASSES_DEF,
  parameter int MAX_LABELS  = ctcgsa_pkg::MAX_LABELS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire ctcgsa_pkg::in_item_t                 in_data,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output ctcgsa_pkg::out_item_t                     out_data,
  // configuration port
  input  wire logic                                 cfg_we,
  input  wire logic [ctcgsa_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [ctcgsa_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int LB = ctcgsa_pkg::LABEL_BITS;
  localparam int SB = ctcgsa_pkg::SCORE_BITS;
  localparam int NB = ctcgsa_pkg::CNT16_BITS;
  localparam int CW = $clog2(MAX_CLASSES + 1);   // class counter
  localparam int SW = $clog2(MAX_STEPS + 1);     // steps, decoded length, match index
  localparam int LW = $clog2(MAX_LABELS + 1);    // truth slots
  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,   // taking score or truth transfers
    ST_PRIME = 3'b010,   // first read of the decoded store in flight
    ST_DIV   = 3'b100    // accuracy divide running
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [LB-1:0] blank_r;
  logic [12:0]   alph_r;
  logic [8:0]    tsteps_r;
  logic [8:0]    llen_r;
  logic [NB-1:0] batch_r;

  // per sample state
  logic signed [SB-1:0] best_score_r, best_score_nxt;
  logic [LB-1:0]        best_class_r, best_class_nxt;
  logic [CW-1:0]        cls_cnt_r, cls_cnt_nxt;
  logic [SW-1:0]        step_cnt_r, step_cnt_nxt;
  logic [LB-1:0]        prev_lbl_r, prev_lbl_nxt;
  logic [SW-1:0]        dec_len_r, dec_len_nxt;
  logic [LW-1:0]        slot_cnt_r, slot_cnt_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic                 mis_r, mis_nxt;
  logic                 truth_r, truth_nxt;

  // per batch state
  logic [NB-1:0] sample_cnt_r, sample_cnt_nxt;
  logic [NB-1:0] hit_total_r, hit_total_nxt;

  // result held while the divider runs
  logic          pend_hit_r, pend_hit_nxt;
  logic [NB-1:0] pend_hits_r, pend_hits_nxt;
  logic [NB-1:0] pend_num_r, pend_num_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  ctcgsa_pkg::out_item_t out_data_r, out_data_nxt;

  // limits after clamping
  logic [CW-1:0] cls_lim;
  logic [SW-1:0] step_lim;
  logic [LW-1:0] slot_lim;
  logic [NB-1:0] bat_lim;

  // store and divider hookup
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [LB-1:0]         ram_wdata;
  logic [LB-1:0]         ram_rdata;
  ctcgsa_pkg::div_req_t  div_req;
  logic                  div_done;
  logic [ctcgsa_pkg::ACC_BITS-1:0] div_quo;

  // scratch
  logic          accept;
  logic          take;
  logic [LB-1:0] cur_class;
  logic [LB-1:0] prev_cmp;
  logic          hit;
  logic [NB-1:0] hits_new;
  logic          batch_end;

  // register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r  <= '0;
      alph_r   <= 13'd4096;
      tsteps_r <= 9'd256;
      llen_r   <= 9'd256;
      batch_r  <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ctcgsa_pkg::CFG_BLANK_LABEL:   blank_r  <= cfg_wdata[LB-1:0];
        ctcgsa_pkg::CFG_ALPHABET_SIZE: alph_r   <= cfg_wdata[12:0];
        ctcgsa_pkg::CFG_TIME_STEPS:    tsteps_r <= cfg_wdata[8:0];
        ctcgsa_pkg::CFG_LABEL_LENGTH:  llen_r   <= cfg_wdata[8:0];
        ctcgsa_pkg::CFG_BATCH_SIZE:    batch_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lengths clamped into [1, max]
  always_comb begin
    if (alph_r == '0) begin
      cls_lim = CW'(1);
    end else if (32'(alph_r) > 32'(MAX_CLASSES)) begin
      cls_lim = CW'(MAX_CLASSES);
    end else begin
      cls_lim = CW'(alph_r);
    end
    if (tsteps_r == '0) begin
      step_lim = SW'(1);
    end else if (32'(tsteps_r) > 32'(MAX_STEPS)) begin
      step_lim = SW'(MAX_STEPS);
    end else begin
      step_lim = SW'(tsteps_r);
    end
    if (llen_r == '0) begin
      slot_lim = LW'(1);
    end else if (32'(llen_r) > 32'(MAX_LABELS)) begin
      slot_lim = LW'(MAX_LABELS);
    end else begin
      slot_lim = LW'(llen_r);
    end
    bat_lim = (batch_r == '0) ? NB'(1) : batch_r;
  end

  // truth transfers wait while a result still sits in the output register
  assign in_stall = (state_r != ST_RUN) || (truth_r && out_valid_r);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    cls_cnt_nxt    = cls_cnt_r;
    step_cnt_nxt   = step_cnt_r;
    prev_lbl_nxt   = prev_lbl_r;
    dec_len_nxt    = dec_len_r;
    slot_cnt_nxt   = slot_cnt_r;
    idx_nxt        = idx_r;
    mis_nxt        = mis_r;
    truth_nxt      = truth_r;
    sample_cnt_nxt = sample_cnt_r;
    hit_total_nxt  = hit_total_r;
    pend_hit_nxt   = pend_hit_r;
    pend_hits_nxt  = pend_hits_r;
    pend_num_nxt   = pend_num_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = dec_len_r[AW-1:0];
    ram_wdata      = '0;
    div_req        = '0;
    hit            = 1'b0;
    hits_new       = hit_total_r;
    batch_end      = 1'b0;

    // argmax update, tie keeps the lower class
    take      = (cls_cnt_r == '0) || (in_data.score > best_score_r);
    cur_class = take ? LB'(cls_cnt_r) : best_class_r;
    prev_cmp  = (step_cnt_r == '0) ? blank_r : prev_lbl_r;

    unique case (state_r)
      ST_RUN: begin
        if (accept && !truth_r && in_data.cmd == ctcgsa_pkg::CMD_SCORE) begin
          best_class_nxt = cur_class;
          if (take) begin
            best_score_nxt = in_data.score;
          end
          cls_cnt_nxt = cls_cnt_r + 1'b1;
          if (32'(cls_cnt_r) + 32'd1 >= 32'(cls_lim)) begin
            // end of a time step: collapse repeats, drop blanks
            if (cur_class != prev_cmp && cur_class != blank_r &&
                32'(dec_len_r) < 32'(MAX_STEPS)) begin
              ram_we      = 1'b1;
              ram_wdata   = cur_class;
              dec_len_nxt = dec_len_r + 1'b1;
            end
            prev_lbl_nxt   = cur_class;
            cls_cnt_nxt    = '0;
            best_score_nxt = {1'b1, {(SB-1){1'b0}}};
            best_class_nxt = '0;
            step_cnt_nxt   = step_cnt_r + 1'b1;
            if (32'(step_cnt_r) + 32'd1 >= 32'(step_lim)) begin
              truth_nxt    = 1'b1;
              slot_cnt_nxt = '0;
              idx_nxt      = '0;
              mis_nxt      = 1'b0;
              state_nxt    = ST_PRIME;
            end
          end
        end else if (accept && truth_r && in_data.cmd == ctcgsa_pkg::CMD_TRUTH) begin
          // ram_rdata holds the decoded entry at idx_r
          if (in_data.truth_label != blank_r) begin
            if (idx_r < dec_len_r && 32'(idx_r) < 32'(MAX_STEPS) &&
                ram_rdata == in_data.truth_label) begin
              idx_nxt = idx_r + 1'b1;
            end else begin
              mis_nxt = 1'b1;
            end
          end
          slot_cnt_nxt = slot_cnt_r + 1'b1;
          if (32'(slot_cnt_r) + 32'd1 >= 32'(slot_lim)) begin
            hit       = !mis_nxt && (idx_nxt == dec_len_r);
            hits_new  = hit_total_r + NB'(hit);
            batch_end = (32'(sample_cnt_r) + 32'd1 >= 32'(bat_lim));
            if (batch_end) begin
              pend_hit_nxt   = hit;
              pend_hits_nxt  = hits_new;
              pend_num_nxt   = sample_cnt_r;
              div_req.start  = 1'b1;
              div_req.num    = hits_new;
              div_req.den    = bat_lim;
              sample_cnt_nxt = '0;
              hit_total_nxt  = '0;
              state_nxt      = ST_DIV;
            end else begin
              out_valid_nxt              = 1'b1;
              out_data_nxt.sample_hit    = hit;
              out_data_nxt.hits_so_far   = hits_new;
              out_data_nxt.sample_number = sample_cnt_r;
              out_data_nxt.accuracy_q16  = '0;
              out_data_nxt.batch_done    = 1'b0;
              sample_cnt_nxt             = sample_cnt_r + 1'b1;
              hit_total_nxt              = hits_new;
            end
            // start of the next sample
            best_score_nxt = {1'b1, {(SB-1){1'b0}}};
            best_class_nxt = '0;
            cls_cnt_nxt    = '0;
            step_cnt_nxt   = '0;
            prev_lbl_nxt   = blank_r;
            dec_len_nxt    = '0;
            slot_cnt_nxt   = '0;
            idx_nxt        = '0;
            mis_nxt        = 1'b0;
            truth_nxt      = 1'b0;
          end
        end
      end
      ST_PRIME: begin
        state_nxt = ST_RUN;
      end
      ST_DIV: begin
        if (div_done) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.sample_hit    = pend_hit_r;
          out_data_nxt.hits_so_far   = pend_hits_r;
          out_data_nxt.sample_number = pend_num_r;
          out_data_nxt.accuracy_q16  = div_quo;
          out_data_nxt.batch_done    = 1'b1;
          state_nxt                  = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      best_score_r <= {1'b1, {(SB-1){1'b0}}};
      best_class_r <= '0;
      cls_cnt_r    <= '0;
      step_cnt_r   <= '0;
      prev_lbl_r   <= '0;
      dec_len_r    <= '0;
      slot_cnt_r   <= '0;
      idx_r        <= '0;
      mis_r        <= 1'b0;
      truth_r      <= 1'b0;
      sample_cnt_r <= '0;
      hit_total_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      cls_cnt_r    <= cls_cnt_nxt;
      step_cnt_r   <= step_cnt_nxt;
      prev_lbl_r   <= prev_lbl_nxt;
      dec_len_r    <= dec_len_nxt;
      slot_cnt_r   <= slot_cnt_nxt;
      idx_r        <= idx_nxt;
      mis_r        <= mis_nxt;
      truth_r      <= truth_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      hit_total_r  <= hit_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_hit_r  <= pend_hit_nxt;
    pend_hits_r <= pend_hits_nxt;
    pend_num_r  <= pend_num_nxt;
    out_data_r  <= out_data_nxt;
  end

  // decoded sequence store, read ahead at the next match index
  ctcgsa_ram #(
    .WIDTH (LB),
    .DEPTH (MAX_STEPS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt[AW-1:0]),
    .rdata (ram_rdata)
  );

  // accuracy divider
  ctcgsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== verif/ctc_greedy_sequence_accuracy_top_tb.sv =====
// testbench: ctc greedy decode accuracy block checked against an in-bench decoder
`timescale 1ns / 100ps
module ctc_greedy_sequence_accuracy_top_tb;

  localparam int DRAIN_CYCLES = 24;      // drain time for the divider to finish, plus margin
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int CYCLE_LIMIT  = 500000;
  localparam int ITEM_GOAL    = 1900;

  // directed script: register writes and items, some with the result typed in
  typedef enum logic [1:0] {ROW_REG, ROW_SCORE, ROW_TRUTH} row_kind_t;

  typedef struct packed {
    row_kind_t                               kind;
    logic [ctcgsa_pkg::CFG_IDX_BITS-1:0]     reg_idx;
    logic [15:0]                             value;    // register value, score or label
    logic                                    typed;
    ctcgsa_pkg::out_item_t                   result;
  } script_row_t;

  localparam int SCRIPT_ROWS = 30;
  localparam script_row_t SCRIPT [0:SCRIPT_ROWS-1] = '{
    // small shape, batch of two
    '{ROW_REG,   ctcgsa_pkg::CFG_BLANK_LABEL,   16'd0,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_ALPHABET_SIZE, 16'd3,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_TIME_STEPS,    16'd2,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_LABEL_LENGTH,  16'd2,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_BATCH_SIZE,    16'd2,     1'b0, '0},
    // tie at the top goes to class 0, the blank
    '{ROW_SCORE, '0,                16'h7FFF,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h8000,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h7FFF,  1'b0, '0},
    // truth slot while scores are expected: ignored
    '{ROW_TRUTH, '0,                16'h0ABC,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h8000,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h8000,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h0005,  1'b0, '0},
    // blank slot skipped, then the one decoded label: a hit
    '{ROW_TRUTH, '0,                16'h0000,  1'b0, '0},
    '{ROW_TRUTH, '0,                16'h0002,  1'b1, '{1'b1, 16'd1, 16'd0, 17'd0, 1'b0}},
    // all scores at the floor: class 0 wins
    '{ROW_SCORE, '0,                16'h8000,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h8000,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h8000,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h0001,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h0007,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h0007,  1'b0, '0},
    // score while truth is expected: ignored
    '{ROW_SCORE, '0,                16'h1234,  1'b0, '0},
    '{ROW_TRUTH, '0,                16'h0001,  1'b0, '0},
    // extra non-blank label: miss, batch ends at half accuracy
    '{ROW_TRUTH, '0,                16'h0FFF,  1'b1, '{1'b0, 16'd1, 16'd1, 17'd32768, 1'b1}},
    // zero lengths clamp to one, blank moves to the top label
    '{ROW_REG,   ctcgsa_pkg::CFG_ALPHABET_SIZE, 16'd0,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_TIME_STEPS,    16'd0,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_LABEL_LENGTH,  16'd0,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_BATCH_SIZE,    16'd0,     1'b0, '0},
    '{ROW_REG,   ctcgsa_pkg::CFG_BLANK_LABEL,   16'h0FFF,  1'b0, '0},
    '{ROW_SCORE, '0,                16'h0100,  1'b0, '0},
    '{ROW_TRUTH, '0,                16'h0000,  1'b1,
      '{1'b1, 16'd1, 16'd0, ctcgsa_pkg::ACC_ONE, 1'b1}}
  };

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  ctcgsa_pkg::in_item_t                 in_data = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  ctcgsa_pkg::out_item_t                out_data;
  logic                                 cfg_we = 1'b0;
  logic [ctcgsa_pkg::CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [ctcgsa_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  ctc_greedy_sequence_accuracy_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // register mirror, as last written
  logic [11:0] blank_q;
  logic [12:0] alph_q;
  logic [8:0]  steps_q;
  logic [8:0]  labels_q;
  logic [15:0] batch_q;

  // decoder state mirror
  logic signed [ctcgsa_pkg::SCORE_BITS-1:0] best_score;
  logic [11:0] best_class;
  int unsigned class_cnt, step_cnt, dec_len, slot_cnt, match_idx;
  logic [11:0] prev_label;
  logic [11:0] decoded [0:ctcgsa_pkg::MAX_STEPS_DEF-1];
  bit          mismatch_seen, truth_phase;
  logic [15:0] sample_cnt, hit_cnt;

  ctcgsa_pkg::out_item_t awaited_results [$];
  ctcgsa_pkg::out_item_t typed_result;
  bit        typed_armed = 1'b0;
  int        mismatch_count = 0;
  int        fed_items = 0;

  // stimulus shaping knobs for the sender and the receiver
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit wide_scores = 1'b0;
  int hold_left = 0;

  function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void add_awaited(input ctcgsa_pkg::out_item_t r);
    awaited_results = {awaited_results, r};
  endfunction

  function automatic void start_sample();
    best_score    = 16'sh8000;
    best_class    = '0;
    class_cnt     = 0;
    step_cnt      = 0;
    prev_label    = blank_q;
    dec_len       = 0;
    slot_cnt      = 0;
    match_idx     = 0;
    mismatch_seen = 1'b0;
    truth_phase   = 1'b0;
  endfunction

  // one accepted item into the decoder mirror; returns 1 when a sample result is due
  function automatic bit decode_and_compare(input ctcgsa_pkg::in_item_t it,
                                            output ctcgsa_pkg::out_item_t res);
    logic [11:0] prev, cur;
    bit          hit, done;
    int unsigned batch_n;
    longint      quo;
    res = '0;
    if (!truth_phase) begin
      if (it.cmd != ctcgsa_pkg::CMD_SCORE) return 1'b0;
      if (class_cnt == 0 || $signed(it.score) > best_score) begin
        best_score = it.score;
        best_class = class_cnt[11:0];
      end
      class_cnt++;
      if (class_cnt >= clamp_len(alph_q, ctcgsa_pkg::MAX_CLASSES_DEF)) begin
        // first step of a sample compares against the blank
        prev = (step_cnt == 0) ? blank_q : prev_label;
        cur  = best_class;
        if (cur != prev && cur != blank_q && dec_len < ctcgsa_pkg::MAX_STEPS_DEF) begin
          decoded[dec_len] = cur;
          dec_len++;
        end
        prev_label = cur;
        class_cnt  = 0;
        best_score = 16'sh8000;
        best_class = '0;
        step_cnt++;
        if (step_cnt >= clamp_len(steps_q, ctcgsa_pkg::MAX_STEPS_DEF)) begin
          truth_phase   = 1'b1;
          slot_cnt      = 0;
          match_idx     = 0;
          mismatch_seen = 1'b0;
        end
      end
      return 1'b0;
    end
    if (it.cmd != ctcgsa_pkg::CMD_TRUTH) return 1'b0;
    if (it.truth_label != blank_q) begin
      if (match_idx < dec_len && decoded[match_idx] == it.truth_label) match_idx++;
      else mismatch_seen = 1'b1;
    end
    slot_cnt++;
    if (slot_cnt < clamp_len(labels_q, ctcgsa_pkg::MAX_LABELS_DEF)) return 1'b0;
    hit = !mismatch_seen && match_idx == dec_len;
    if (hit) hit_cnt++;
    res.sample_hit    = hit;
    res.hits_so_far   = hit_cnt;
    res.sample_number = sample_cnt;
    sample_cnt++;
    batch_n = clamp_len(batch_q, 65535);
    done    = sample_cnt >= batch_n;
    if (done) begin
      // hits can pass the batch size if it was lowered mid-batch: saturate at 1.0
      quo = (longint'(hit_cnt) << 16) / batch_n;
      res.accuracy_q16 = (quo > 65536) ? ctcgsa_pkg::ACC_ONE
                                       : ctcgsa_pkg::ACC_BITS'(quo);
      sample_cnt = '0;
      hit_cnt    = '0;
    end
    res.batch_done = done;
    start_sample();
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatch_count < 100) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // everything sampled at the rising edge: register mirror, predictions, result checks
  always @(posedge clk) begin
    ctcgsa_pkg::out_item_t guess, want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          ctcgsa_pkg::CFG_BLANK_LABEL:   blank_q  = cfg_wdata[11:0];
          ctcgsa_pkg::CFG_ALPHABET_SIZE: alph_q   = cfg_wdata[12:0];
          ctcgsa_pkg::CFG_TIME_STEPS:    steps_q  = cfg_wdata[8:0];
          ctcgsa_pkg::CFG_LABEL_LENGTH:  labels_q = cfg_wdata[8:0];
          ctcgsa_pkg::CFG_BATCH_SIZE:    batch_q  = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall && decode_and_compare(in_data, guess)) begin
        // typed rows override the predictor with a hand-written result
        if (typed_armed) begin
          add_awaited(typed_result);
          typed_armed = 1'b0;
        end else begin
          add_awaited(guess);
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          log_mismatch("result transfer with nothing awaited");
        end else begin
          want = awaited_results.pop_front();
          if (out_data.sample_hit !== want.sample_hit)
            log_mismatch($sformatf("sample_hit %0d, want %0d",
                                   out_data.sample_hit, want.sample_hit));
          if (out_data.hits_so_far !== want.hits_so_far)
            log_mismatch($sformatf("hits_so_far %0d, want %0d",
                                   out_data.hits_so_far, want.hits_so_far));
          if (out_data.sample_number !== want.sample_number)
            log_mismatch($sformatf("sample_number %0d, want %0d",
                                   out_data.sample_number, want.sample_number));
          if (out_data.accuracy_q16 !== want.accuracy_q16)
            log_mismatch($sformatf("accuracy_q16 %0d, want %0d",
                                   out_data.accuracy_q16, want.accuracy_q16));
          if (out_data.batch_done !== want.batch_done)
            log_mismatch($sformatf("batch_done %0d, want %0d",
                                   out_data.batch_done, want.batch_done));
        end
      end
    end
  end

  // receiver: random stalls, none while quiet, and one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 20);
    end
  end

  // one transfer on the input channel; called and returns at a falling edge
  task automatic send_item(input ctcgsa_pkg::in_item_t it, input bit counts);
    int gap;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < 20) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (counts) fed_items++;
  endtask

  // now and then an item of the wrong kind for the current phase
  task automatic maybe_noise(input bit noisy, input logic kind);
    ctcgsa_pkg::in_item_t it;
    if (noisy && $urandom_range(19) == 0) begin
      it.cmd         = kind;
      it.score       = 16'($urandom_range(65535));
      it.truth_label = 12'($urandom_range(4095));
      send_item(it, 1'b0);
    end
  endtask

  // wait until every result is in and the divider has had time to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [ctcgsa_pkg::CFG_IDX_BITS-1:0] idx,
                         input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] blank, input logic [15:0] alph,
                              input logic [15:0] steps, input logic [15:0] labels,
                              input logic [15:0] batch);
    set_reg(ctcgsa_pkg::CFG_BLANK_LABEL, blank);
    set_reg(ctcgsa_pkg::CFG_ALPHABET_SIZE, alph);
    set_reg(ctcgsa_pkg::CFG_TIME_STEPS, steps);
    set_reg(ctcgsa_pkg::CFG_LABEL_LENGTH, labels);
    set_reg(ctcgsa_pkg::CFG_BATCH_SIZE, batch);
  endtask

  // rest of one sample from wherever the decoder stands: scores aimed at a chosen
  // winner per step, then truth built from the decoded labels, mostly matching
  task automatic run_sample(input bit exact_truth, input bit noisy);
    ctcgsa_pkg::in_item_t it;
    logic [11:0] want [$];
    int unsigned slots, k;
    int          peak_class, peak_val, s;
    peak_class = 0;
    peak_val   = 0;
    while (!truth_phase) begin
      if (class_cnt == 0) begin
        peak_class = $urandom_range(clamp_len(alph_q, ctcgsa_pkg::MAX_CLASSES_DEF) - 1);
        if (wide_scores) peak_val = $urandom_range(65535) - 32768;
        else begin
          case ($urandom_range(5))
            0:       peak_val = -32768;
            1:       peak_val = -1;
            2:       peak_val = 0;
            3:       peak_val = 1;
            4:       peak_val = 32767;
            default: peak_val = $urandom_range(16) - 8;
          endcase
        end
      end
      if ($urandom_range(9) < 3) s = $urandom_range(65535) - 32768;
      else if (class_cnt == peak_class) s = peak_val;
      else if (peak_val == -32768 || $urandom_range(7) == 0) s = peak_val;  // tie
      else s = $urandom_range(peak_val + 32767) - 32768;
      maybe_noise(noisy, ctcgsa_pkg::CMD_TRUTH);
      it.cmd         = ctcgsa_pkg::CMD_SCORE;
      it.score       = 16'(s);
      it.truth_label = 12'($urandom_range(4095));
      send_item(it, 1'b1);
    end

    for (int i = 0; i < dec_len; i++) want = {want, decoded[i]};
    if (!exact_truth) begin
      case ($urandom_range(9))
        6: begin
          want.delete();
          repeat ($urandom_range(4)) want = {want, 12'($urandom_range(4095))};
        end
        7: if (want.size() != 0) begin
          k = $urandom_range(want.size() - 1);
          want[k] = want[k] ^ 12'($urandom_range(1, 4095));
        end
        8: want.insert($urandom_range(want.size()), 12'($urandom_range(4095)));
        9: if (want.size() != 0) want.delete($urandom_range(want.size() - 1));
        default: ;
      endcase
    end
    slots = clamp_len(labels_q, ctcgsa_pkg::MAX_LABELS_DEF) - slot_cnt;
    while (want.size() > slots) void'(want.pop_back());
    // labels spread over the slots, blanks in between
    for (k = slots; k > 0; k--) begin
      maybe_noise(noisy, ctcgsa_pkg::CMD_SCORE);
      it.cmd   = ctcgsa_pkg::CMD_TRUTH;
      it.score = 16'($urandom_range(65535));
      if (want.size() != 0 && $urandom_range(k - 1) < want.size())
        it.truth_label = want.pop_front();
      else
        it.truth_label = blank_q;
      send_item(it, 1'b1);
    end
  endtask

  // main stimulus
  initial begin
    ctcgsa_pkg::in_item_t it;
    int unsigned alph, samples, phase;
    blank_q    = '0;
    alph_q     = 13'd4096;
    steps_q    = 9'd256;
    labels_q   = 9'd256;
    batch_q    = 16'd1;
    sample_cnt = '0;
    hit_cnt    = '0;
    start_sample();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed script
    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_REG) begin
        if (r > 0 && SCRIPT[r-1].kind != ROW_REG) settle();
        set_reg(SCRIPT[r].reg_idx, SCRIPT[r].value);
      end else begin
        if (SCRIPT[r].typed) begin
          typed_result = SCRIPT[r].result;
          typed_armed  = 1'b1;
        end
        it.cmd         = (SCRIPT[r].kind == ROW_TRUTH) ? ctcgsa_pkg::CMD_TRUTH
                                                       : ctcgsa_pkg::CMD_SCORE;
        it.score       = SCRIPT[r].value;
        it.truth_label = SCRIPT[r].value[11:0];
        send_item(it, 1'b0);
      end
    end

    // longest sample: every step and every label slot
    settle();
    wide_scores = 1'b0;
    program_regs(16'd2, 16'd2, 16'd511, 16'd511, 16'd3);
    run_sample(1'b1, 1'b0);

    // largest batch, then lowered below the hit count: accuracy saturates
    settle();
    program_regs(16'd0, 16'd1, 16'd1, 16'd1, 16'hFFFF);
    repeat (3) run_sample(1'b1, 1'b0);
    settle();
    set_reg(ctcgsa_pkg::CFG_BATCH_SIZE, 16'd2);
    run_sample(1'b1, 1'b0);

    // alphabet lowered in the middle of a time step ends the step at the next score
    settle();
    program_regs(16'd1, 16'd5, 16'd2, 16'd3, 16'd4);
    repeat (3) begin
      it.cmd         = ctcgsa_pkg::CMD_SCORE;
      it.score       = 16'($urandom_range(65535));
      it.truth_label = 12'($urandom_range(4095));
      send_item(it, 1'b0);
    end
    settle();
    set_reg(ctcgsa_pkg::CFG_ALPHABET_SIZE, 16'd2);
    repeat (3) run_sample(1'b0, 1'b1);

    // random phases: new shape per phase, mostly well-formed samples
    phase = 0;
    while (fed_items < ITEM_GOAL) begin
      settle();
      wide_scores = $urandom_range(1);
      if (phase == 0) begin
        // tiny samples behind a long receiver hold-off so the block backs up
        alph = $urandom_range(1, 2);
        program_regs(16'($urandom_range(alph - 1)), 16'(alph), 16'd1,
                     16'($urandom_range(1, 2)), 16'($urandom_range(1, 6)));
        samples  = 60;
        hold_req = 1'b1;
      end else begin
        alph = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
        program_regs(($urandom_range(3) == 0) ? 16'($urandom_range(4095))
                                              : 16'($urandom_range(clamp_len(alph, 6) - 1)),
                     16'(alph),
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 8)),
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
        samples = $urandom_range(4, 12);
      end
      // one phase runs back to back on both sides
      quiet = (phase == 1);
      repeat (samples) run_sample(1'b0, 1'b1);
      quiet = 1'b0;
      phase++;
    end

    settle();
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // run limit in clock cycles
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== ctc_greedy_sequence_accuracy_top.f =====
design/ctcgsa_pkg.sv
design/ctcgsa_ram.sv
design/ctcgsa_div.sv
design/ctc_greedy_sequence_accuracy_top.sv
verif/ctc_greedy_sequence_accuracy_top_tb.sv
